// ===== hw/rtl/bson_key_lookup_scanner_macros.svh =====
// Assertion macros shared by the BSON key lookup scanner RTL.
// Included by each module that checks its own logic; no other dependencies.
`ifndef BSON_KEY_LOOKUP_SCANNER_MACROS_SVH
`define BSON_KEY_LOOKUP_SCANNER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define BKLS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bkls assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BKLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bkls assertion failed");

`else

`define BKLS_ASSERT_SAME(label, clk, rst, ante, cons)
`define BKLS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/bkls_pkg.sv =====
// Package for the BSON key lookup scanner: payload types, codes and constants.
// No dependencies.
package bkls_pkg;

   localparam int MAX_KEY_BYTES_DEF = 8;
   localparam int OFFSET_BITS_DEF   = 16;

   localparam int KEY_CHARS_BITS    = 64;
   localparam int KEY_LENGTH_BITS   = 4;
   localparam int CSR_INDEX_BITS    = 1;
   localparam int CSR_DATA_BITS     = 64;
   localparam int VALUE_OFFSET_BITS = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_CHARS  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_LENGTH = 1'b1;

   localparam logic [2:0] STATUS_FOUND     = 3'd0;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd1;
   localparam logic [2:0] STATUS_UNKNOWN   = 3'd2;
   localparam logic [2:0] STATUS_TRUNCATED = 3'd3;
   localparam logic [2:0] STATUS_TOO_LARGE = 3'd4;

   // BSON element type codes
   localparam logic [7:0] T_DOUBLE   = 8'h01;
   localparam logic [7:0] T_STRING   = 8'h02;
   localparam logic [7:0] T_DOCUMENT = 8'h03;
   localparam logic [7:0] T_ARRAY    = 8'h04;
   localparam logic [7:0] T_BINARY   = 8'h05;
   localparam logic [7:0] T_BOOL     = 8'h08;
   localparam logic [7:0] T_DATETIME = 8'h09;
   localparam logic [7:0] T_INT32    = 8'h10;
   localparam logic [7:0] T_INT64    = 8'h12;

   localparam int RSP_QUEUE_DEPTH = 3;
   localparam int QUEUE_PTR_BITS  = 2;

   typedef enum logic [2:0] {
      PH_LEN,
      PH_TYPE,
      PH_KEY,
      PH_VLEN,
      PH_SKIP
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [2:0]                   status;
      logic [7:0]                   element_type;
      logic [VALUE_OFFSET_BITS-1:0] value_offset;
   } rsp_type;

   typedef struct packed {
      logic [KEY_CHARS_BITS-1:0]  key_chars;
      logic [KEY_LENGTH_BITS-1:0] key_length;
   } cfg_type;

endpackage

// ===== hw/rtl/bkls_parser.sv =====
// Per-byte BSON element parser: state registers plus combinational next-state logic.
// Depends on bkls_pkg and bson_key_lookup_scanner_macros.svh.
`include "bson_key_lookup_scanner_macros.svh"

module bkls_parser #(
   parameter int MAX_KEY_BYTES = bkls_pkg::MAX_KEY_BYTES_DEF,
   parameter int OFFSET_BITS   = bkls_pkg::OFFSET_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  bkls_pkg::req_type in_item,
   input  bkls_pkg::cfg_type cfg,
   output logic              out_valid,
   output bkls_pkg::rsp_type out_item
);

   localparam int KIW      = $clog2(MAX_KEY_BYTES + 1);
   localparam int SUM_BITS = 34;

   bkls_pkg::phase_type phase_ff, phase_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] doc_len_ff, doc_len_in;
   logic [7:0]             cur_type_ff, cur_type_in;
   logic [31:0]            acc_ff, acc_in;
   logic [OFFSET_BITS-1:0] skip_ff, skip_in;
   logic [KIW-1:0]         key_idx_ff, key_idx_in;
   logic                   match_ff, match_in;
   logic                   verdict_ff, verdict_in;

   logic [KIW-1:0]         kl;
   logic [KIW-1:0]         eff_len;
   logic                   zero_hit;
   logic [7:0]             key_byte;
   logic [7:0]             b;
   logic                   eob;
   logic [31:0]            acc_shift;
   logic [OFFSET_BITS:0]   vs;
   logic                   type_known;
   logic                   type_lenpref;
   logic [3:0]             type_skip;
   logic [SUM_BITS-1:0]    vlen_skip;
   logic [SUM_BITS-1:0]    skip_val;
   logic                   next_past_end;
   logic                   parse;
   logic                   len_last;
   logic                   too_large;
   logic                   doc_short;
   logic                   key_over;
   logic                   key_zero;
   logic                   found;
   logic                   unknown;
   logic                   hop;
   logic                   verdict;

   // ---------------- decode ----------------
   always_comb begin
      b   = in_item.data_byte;
      eob = in_item.end_of_buffer;

      if (cfg.key_length > bkls_pkg::KEY_LENGTH_BITS'(MAX_KEY_BYTES)) begin
         kl = KIW'(MAX_KEY_BYTES);
      end else begin
         kl = KIW'(cfg.key_length);
      end
      eff_len  = kl;
      zero_hit = 1'b0;
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
         if (!zero_hit && (KIW'(i) < kl) && (cfg.key_chars[8*i +: 8] == 8'd0)) begin
            eff_len  = KIW'(i);
            zero_hit = 1'b1;
         end
      end
      key_byte = 8'd0;
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
         if (key_idx_ff == KIW'(i)) begin
            key_byte = cfg.key_chars[8*i +: 8];
         end
      end

      acc_shift = {b, acc_ff[31:8]};
      vs        = (OFFSET_BITS+1)'(pos_ff) + 1'b1;

      type_known   = 1'b1;
      type_lenpref = 1'b0;
      type_skip    = 4'd0;
      unique case (cur_type_ff)
         bkls_pkg::T_INT32: begin
            type_skip = 4'd4;
         end
         bkls_pkg::T_DOUBLE, bkls_pkg::T_DATETIME, bkls_pkg::T_INT64: begin
            type_skip = 4'd8;
         end
         bkls_pkg::T_BOOL: begin
            type_skip = 4'd1;
         end
         bkls_pkg::T_STRING, bkls_pkg::T_DOCUMENT, bkls_pkg::T_ARRAY,
         bkls_pkg::T_BINARY: begin
            type_skip    = 4'd4;
            type_lenpref = 1'b1;
         end
         default: begin
            type_known = 1'b0;
         end
      endcase

      unique case (cur_type_ff)
         bkls_pkg::T_STRING: begin
            vlen_skip = SUM_BITS'(acc_shift);
         end
         bkls_pkg::T_BINARY: begin
            vlen_skip = SUM_BITS'(acc_shift) + 1'b1;
         end
         default: begin
            vlen_skip = (acc_shift < 32'd4) ? '0 : SUM_BITS'(acc_shift - 32'd4);
         end
      endcase

      skip_val      = (phase_ff == bkls_pkg::PH_VLEN) ? vlen_skip : SUM_BITS'(type_skip);
      next_past_end = (SUM_BITS'(vs) + skip_val + 1'b1) >= SUM_BITS'(doc_len_ff);

      parse     = in_valid && !verdict_ff;
      len_last  = (phase_ff == bkls_pkg::PH_LEN) && (pos_ff == OFFSET_BITS'(3));
      too_large = (acc_shift >> OFFSET_BITS) != 32'd0;
      doc_short = acc_shift <= 32'd5;
      key_over  = (phase_ff == bkls_pkg::PH_KEY) && (pos_ff >= doc_len_ff);
      key_zero  = (phase_ff == bkls_pkg::PH_KEY) && !key_over && (b == 8'd0);
      found     = key_zero && match_ff && (key_idx_ff == eff_len);
      unknown   = key_zero && !found && !type_known;
      hop       = (key_zero && !found && type_known)
                  || ((phase_ff == bkls_pkg::PH_VLEN) && (skip_ff == OFFSET_BITS'(1)));
      verdict   = parse && ((len_last && (too_large || doc_short)) || key_over || found
                            || unknown || (hop && next_past_end));
   end

   // ---------------- next state ----------------
   always_comb begin
      phase_in = phase_ff;
      if (in_valid && eob) begin
         phase_in = bkls_pkg::PH_LEN;
      end else if (parse && !verdict) begin
         unique case (phase_ff)
            bkls_pkg::PH_LEN: begin
               phase_in = len_last ? bkls_pkg::PH_TYPE : bkls_pkg::PH_LEN;
            end
            bkls_pkg::PH_TYPE: begin
               phase_in = bkls_pkg::PH_KEY;
            end
            bkls_pkg::PH_KEY: begin
               if (key_zero) begin
                  phase_in = type_lenpref ? bkls_pkg::PH_VLEN : bkls_pkg::PH_SKIP;
               end
            end
            bkls_pkg::PH_VLEN: begin
               if (hop) begin
                  phase_in = (skip_val == '0) ? bkls_pkg::PH_TYPE : bkls_pkg::PH_SKIP;
               end
            end
            bkls_pkg::PH_SKIP: begin
               if (skip_ff <= OFFSET_BITS'(1)) begin
                  phase_in = bkls_pkg::PH_TYPE;
               end
            end
            default: begin
               phase_in = bkls_pkg::PH_LEN;
            end
         endcase
      end
   end

   // ---------------- datapath and outputs ----------------
   always_comb begin
      pos_in      = pos_ff;
      doc_len_in  = doc_len_ff;
      cur_type_in = cur_type_ff;
      acc_in      = acc_ff;
      skip_in     = skip_ff;
      key_idx_in  = key_idx_ff;
      match_in    = match_ff;
      verdict_in  = verdict_ff;

      if (in_valid && eob) begin
         pos_in      = '0;
         doc_len_in  = '0;
         cur_type_in = 8'd0;
         acc_in      = 32'd0;
         skip_in     = '0;
         key_idx_in  = '0;
         match_in    = 1'b1;
         verdict_in  = 1'b0;
      end else if (verdict) begin
         verdict_in = 1'b1;
      end else if (parse) begin
         pos_in = pos_ff + 1'b1;
         unique case (phase_ff)
            bkls_pkg::PH_LEN: begin
               acc_in = acc_shift;
               if (len_last) begin
                  doc_len_in = acc_shift[OFFSET_BITS-1:0];
               end
            end
            bkls_pkg::PH_TYPE: begin
               cur_type_in = b;
               key_idx_in  = '0;
               match_in    = 1'b1;
            end
            bkls_pkg::PH_KEY: begin
               if (key_zero) begin
                  skip_in = OFFSET_BITS'(skip_val);
               end else if (match_ff) begin
                  if ((key_idx_ff < eff_len) && (b == key_byte)) begin
                     key_idx_in = key_idx_ff + 1'b1;
                  end else begin
                     match_in = 1'b0;
                  end
               end
            end
            bkls_pkg::PH_VLEN: begin
               acc_in  = acc_shift;
               skip_in = hop ? OFFSET_BITS'(skip_val) : skip_ff - 1'b1;
            end
            bkls_pkg::PH_SKIP: begin
               if (skip_ff != '0) begin
                  skip_in = skip_ff - 1'b1;
               end
            end
            default: begin
               skip_in = skip_ff;
            end
         endcase
      end

      out_valid = parse && (verdict || eob);
      out_item  = '0;
      if (!verdict) begin
         out_item.status = bkls_pkg::STATUS_TRUNCATED;
      end else if (len_last && too_large) begin
         out_item.status = bkls_pkg::STATUS_TOO_LARGE;
      end else if (found) begin
         out_item.status       = bkls_pkg::STATUS_FOUND;
         out_item.element_type = cur_type_ff;
         out_item.value_offset = bkls_pkg::VALUE_OFFSET_BITS'(vs);
      end else if (unknown) begin
         out_item.status = bkls_pkg::STATUS_UNKNOWN;
      end else begin
         out_item.status = bkls_pkg::STATUS_NOT_FOUND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= bkls_pkg::PH_LEN;
         pos_ff      <= '0;
         doc_len_ff  <= '0;
         cur_type_ff <= 8'd0;
         acc_ff      <= 32'd0;
         skip_ff     <= '0;
         key_idx_ff  <= '0;
         match_ff    <= 1'b1;
         verdict_ff  <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         doc_len_ff  <= doc_len_in;
         cur_type_ff <= cur_type_in;
         acc_ff      <= acc_in;
         skip_ff     <= skip_in;
         key_idx_ff  <= key_idx_in;
         match_ff    <= match_in;
         verdict_ff  <= verdict_in;
      end
   end

   // one verdict per buffer
   `BKLS_ASSERT_SAME(a_single_verdict, clock, reset, in_valid && verdict_ff, !out_valid)
   // end of buffer always rearms the parser
   `BKLS_ASSERT_NEXT(a_eob_rearms, clock, reset, in_valid && in_item.end_of_buffer,
                     (phase_ff == bkls_pkg::PH_LEN) && !verdict_ff && (pos_ff == '0))
   // length field counter stays within four bytes
   `BKLS_ASSERT_SAME(a_vlen_count, clock, reset, phase_ff == bkls_pkg::PH_VLEN,
                     (skip_ff != '0) && (skip_ff <= OFFSET_BITS'(4)))

endmodule

// ===== hw/rtl/bkls_rsp_queue.sv =====
// Three-entry response queue that decouples the parser from the rsp channel.
// Depends on bkls_pkg and bson_key_lookup_scanner_macros.svh.
`include "bson_key_lookup_scanner_macros.svh"

module bkls_rsp_queue (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push,
   input  bkls_pkg::rsp_type                      push_item,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output bkls_pkg::rsp_type                      rsp_payload,
   output logic [bkls_pkg::QUEUE_PTR_BITS-1:0]    count
);

   localparam int PB = bkls_pkg::QUEUE_PTR_BITS;
   localparam logic [PB-1:0] LAST = PB'(bkls_pkg::RSP_QUEUE_DEPTH - 1);
   localparam logic [PB-1:0] FULL = PB'(bkls_pkg::RSP_QUEUE_DEPTH);

   bkls_pkg::rsp_type entry_ff [bkls_pkg::RSP_QUEUE_DEPTH];
   logic [PB-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PB-1:0]     count_ff, count_in;
   logic              pop;

   always_comb begin
      pop         = rsp_valid && !rsp_stall;
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      count_in    = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   assign rsp_valid   = count_ff != '0;
   assign rsp_payload = entry_ff[rd_ptr_ff];
   assign count       = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // upstream throttling must leave a free slot for every result
   `BKLS_ASSERT_SAME(a_no_overflow, clock, reset, push, count_ff != FULL)

endmodule

// ===== hw/rtl/bson_key_lookup_scanner.sv =====
// BSON key lookup scanner: one document byte per request, at most one verdict per buffer.
// Path: the input register feeds the parser; its verdict is registered in the rsp queue.
// Throughput: 1 byte per cycle unless req_stall is high; req_stall rises only when the
//   3-entry response queue plus the input register byte could not absorb another result.
// Reset: synchronous, active high; clears parser state, queue and key registers.
// Depends on bkls_pkg, bkls_parser and bkls_rsp_queue.
module bson_key_lookup_scanner #(
   parameter int MAX_KEY_BYTES = bkls_pkg::MAX_KEY_BYTES_DEF,
   parameter int OFFSET_BITS   = bkls_pkg::OFFSET_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bkls_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bkls_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_write_enable,
   input  logic [bkls_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bkls_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int PB = bkls_pkg::QUEUE_PTR_BITS;

   logic              in_valid_ff;
   bkls_pkg::req_type in_item_ff;
   bkls_pkg::cfg_type cfg_ff;
   logic              res_valid;
   bkls_pkg::rsp_type res_item;
   logic [PB-1:0]     queue_count;
   logic [PB:0]       backlog;

   assign backlog   = (PB+1)'(queue_count) + (PB+1)'(in_valid_ff);
   assign req_stall = backlog > (PB+1)'(bkls_pkg::RSP_QUEUE_DEPTH - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_valid && !req_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bkls_pkg::CSR_KEY_CHARS: begin
               cfg_ff.key_chars <= csr_write_data[bkls_pkg::KEY_CHARS_BITS-1:0];
            end
            bkls_pkg::CSR_KEY_LENGTH: begin
               cfg_ff.key_length <= csr_write_data[bkls_pkg::KEY_LENGTH_BITS-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   bkls_parser #(
      .MAX_KEY_BYTES(MAX_KEY_BYTES),
      .OFFSET_BITS  (OFFSET_BITS)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid_ff),
      .in_item  (in_item_ff),
      .cfg      (cfg_ff),
      .out_valid(res_valid),
      .out_item (res_item)
   );

   bkls_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_item  (res_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .count      (queue_count)
   );

endmodule

// ===== tb/sv/bson_key_lookup_scanner_tb.sv =====
// Self-checking testbench for the BSON key lookup scanner: builds BSON buffers,
// predicts the verdict of each one and compares it with the responses.
// Depends on bkls_pkg and bson_key_lookup_scanner.
`timescale 1ns / 1ps

module bson_key_lookup_scanner_tb;
   import bkls_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned SETTLE_CYCLES   = 4;
   localparam int unsigned REPORT_LIMIT    = 10;
   localparam int unsigned RANDOM_REQUESTS = 800;
   localparam int unsigned MIN_BUFFERS     = 12;
   localparam int unsigned OFFSET_MAX      = (1 << OFFSET_BITS_DEF) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_payload;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_write_data = '0;

   bson_key_lookup_scanner i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // scanner state as predicted
   logic [63:0] key_chars_cfg  = '0;
   logic [3:0]  key_length_cfg = '0;
   phase_type   scan_phase;
   int unsigned scan_pos, doc_len, len_acc, skip_left, key_idx;
   logic [7:0]  elem_type;
   bit          key_ok, verdict_done;

   req_type     request_feed[$];
   rsp_type     expected_verdicts[$];
   logic [7:0]  doc_bytes[$];
   int unsigned fed_requests = 0;
   int unsigned buffers_fed  = 0;
   int unsigned mismatches   = 0;
   int unsigned cycle_count  = 0;
   int unsigned burst_left, gap_left, stall_mode, mode_left;

   function automatic void clear_scan();
      scan_phase   = PH_LEN;
      scan_pos     = 0;
      doc_len      = 0;
      elem_type    = 8'h00;
      len_acc      = 0;
      skip_left    = 0;
      key_idx      = 0;
      key_ok       = 1'b1;
      verdict_done = 1'b0;
   endfunction

   function automatic int unsigned key_span();
      int unsigned n;
      n = (key_length_cfg > MAX_KEY_BYTES_DEF) ? MAX_KEY_BYTES_DEF : key_length_cfg;
      for (int i = 0; i < n; i++) begin
         if (key_chars_cfg[i*8 +: 8] == 8'h00) return i;
      end
      return n;
   endfunction

   function automatic bit post_verdict(logic [2:0] st, logic [7:0] ty, longint unsigned off);
      rsp_type v;
      v.status       = st;
      v.element_type = ty;
      v.value_offset = off[VALUE_OFFSET_BITS-1:0];
      expected_verdicts.push_back(v);
      verdict_done = 1'b1;
      return 1'b1;
   endfunction

   // nxt: offset of the next element's type byte
   function automatic bit jump_to(longint unsigned nxt);
      longint unsigned here;
      here = longint'(scan_pos) + 1;
      if (nxt + 1 >= doc_len || nxt < here) return post_verdict(STATUS_NOT_FOUND, 8'h00, 0);
      skip_left  = 32'(nxt - here);
      scan_phase = (skip_left == 0) ? PH_TYPE : PH_SKIP;
      return 1'b0;
   endfunction

   function automatic bit key_ended();
      longint unsigned vs;
      vs = longint'(scan_pos) + 1;
      if (key_ok && key_idx == key_span()) return post_verdict(STATUS_FOUND, elem_type, vs);
      case (elem_type)
         T_INT32: return jump_to(vs + 4);
         T_DOUBLE, T_DATETIME, T_INT64: return jump_to(vs + 8);
         T_BOOL: return jump_to(vs + 1);
         T_STRING, T_DOCUMENT, T_ARRAY, T_BINARY: begin
            if (vs + 5 >= doc_len) return post_verdict(STATUS_NOT_FOUND, 8'h00, 0);
            len_acc    = 0;
            skip_left  = 4;
            scan_phase = PH_VLEN;
            return 1'b0;
         end
         default: return post_verdict(STATUS_UNKNOWN, 8'h00, 0);
      endcase
   endfunction

   function automatic bit value_len_known();
      longint unsigned here, ln;
      here = longint'(scan_pos) + 1;
      ln   = len_acc;
      if (elem_type == T_STRING) return jump_to(here + ln);
      if (elem_type == T_BINARY) return jump_to(here + 1 + ln);
      return jump_to(here + ((ln < 4) ? 0 : ln - 4));
   endfunction

   function automatic bit scan_body(logic [7:0] b);
      bit hit;
      hit = 1'b0;
      case (scan_phase)
         PH_LEN: begin
            len_acc = len_acc | ({24'd0, b} << ((scan_pos & 3) * 8));
            if (scan_pos >= 3) begin
               if (len_acc > OFFSET_MAX) begin
                  hit = post_verdict(STATUS_TOO_LARGE, 8'h00, 0);
               end else begin
                  doc_len = len_acc;
                  len_acc = 0;
                  if (doc_len <= 5) hit = post_verdict(STATUS_NOT_FOUND, 8'h00, 0);
                  else scan_phase = PH_TYPE;
               end
            end
         end
         PH_TYPE: begin
            elem_type  = b;
            key_idx    = 0;
            key_ok     = 1'b1;
            scan_phase = PH_KEY;
         end
         PH_KEY: begin
            if (scan_pos >= doc_len) begin
               hit = post_verdict(STATUS_NOT_FOUND, 8'h00, 0);
            end else if (b == 8'h00) begin
               hit = key_ended();
            end else if (key_ok) begin
               if (key_idx < key_span() && b == key_chars_cfg[key_idx*8 +: 8]) key_idx++;
               else key_ok = 1'b0;
            end
         end
         PH_VLEN: begin
            len_acc = len_acc | ({24'd0, b} << (((4 - skip_left) & 3) * 8));
            skip_left--;
            if (skip_left == 0) hit = value_len_known();
         end
         PH_SKIP: begin
            if (skip_left > 0) skip_left--;
            if (skip_left == 0) scan_phase = PH_TYPE;
         end
         default: scan_phase = PH_LEN;
      endcase
      scan_pos++;
      return hit;
   endfunction

   function automatic void scan_request(req_type r);
      bit hit;
      if (!verdict_done) begin
         hit = scan_body(r.data_byte);
         if (!hit && r.end_of_buffer) hit = post_verdict(STATUS_TRUNCATED, 8'h00, 0);
      end
      if (r.end_of_buffer) clear_scan();
   endfunction

   // ---------------------------------------------------------------- buffers

   function automatic logic [7:0] element_code(int unsigned sel);
      case (sel)
         0: return T_DOUBLE;
         1: return T_STRING;
         2: return T_DOCUMENT;
         3: return T_ARRAY;
         4: return T_BINARY;
         5: return T_BOOL;
         6: return T_DATETIME;
         7: return T_INT32;
         8: return T_INT64;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic add_noise(int unsigned n);
      repeat (n) doc_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic add_le32(int unsigned v);
      for (int i = 0; i < 4; i++) doc_bytes.push_back(v[i*8 +: 8]);
   endtask

   // vsize < 0 picks a random value size
   task automatic add_element(logic [7:0] ty, bit hit, int vsize);
      int unsigned span, n;
      logic [7:0] last;
      span = key_span();
      doc_bytes.push_back(ty);
      if (hit || $urandom_range(0, 3) == 0) begin
         for (int i = 0; i < span; i++) doc_bytes.push_back(key_chars_cfg[i*8 +: 8]);
         if (!hit) begin
            if (span > 0 && $urandom_range(0, 1) == 1) begin
               last = doc_bytes.pop_back();
               doc_bytes.push_back(last ^ (8'h01 << $urandom_range(0, 7)));
            end else begin
               doc_bytes.push_back(8'($urandom_range(1, 255)));
            end
         end
      end else begin
         n = $urandom_range(0, 9);
         repeat (n) doc_bytes.push_back(8'($urandom_range(1, 255)));
      end
      doc_bytes.push_back(8'h00);
      case (ty)
         T_INT32: add_noise(4);
         T_DOUBLE, T_DATETIME, T_INT64: add_noise(8);
         T_BOOL: add_noise(1);
         T_STRING, T_BINARY: begin
            if (vsize >= 0) n = vsize;
            else if ($urandom_range(0, 59) == 0) n = $urandom_range(100, 1500);
            else n = $urandom_range(0, 12);
            add_le32(n);
            add_noise((ty == T_BINARY) ? n + 1 : n);
         end
         T_DOCUMENT, T_ARRAY: begin
            if (vsize >= 0) n = vsize;
            else if ($urandom_range(0, 7) == 0) n = $urandom_range(0, 3);
            else n = $urandom_range(4, 24);
            add_le32(n);
            add_noise((n < 4) ? 0 : n - 4);
         end
         default: add_noise($urandom_range(0, 6));
      endcase
   endtask

   task automatic feed_buffer();
      req_type r;
      foreach (doc_bytes[i]) begin
         r.data_byte     = doc_bytes[i];
         r.end_of_buffer = (i == doc_bytes.size() - 1);
         request_feed.push_back(r);
      end
      fed_requests += doc_bytes.size();
      buffers_fed++;
      doc_bytes.delete();
   endtask

   // forced_len < 0 uses the true length
   task automatic finish_document(longint forced_len, bit cut, int unsigned tail);
      int unsigned total, keep;
      doc_bytes.push_back(8'h00);
      total = (forced_len < 0) ? doc_bytes.size() + 4 : forced_len[31:0];
      for (int i = 3; i >= 0; i--) doc_bytes.push_front(total[i*8 +: 8]);
      if (cut) begin
         keep = $urandom_range(1, doc_bytes.size() - 1);
         while (doc_bytes.size() > keep) void'(doc_bytes.pop_back());
      end
      add_noise(tail);
      feed_buffer();
   endtask

   task automatic queue_random_buffer();
      int unsigned kind, elems, hit_at;
      longint forced;
      kind = $urandom_range(0, 11);
      if (kind == 0) begin
         add_noise($urandom_range(1, 12));
         feed_buffer();
      end else begin
         elems  = $urandom_range(0, 6);
         hit_at = $urandom_range(0, elems + 1);
         for (int e = 0; e < elems; e++) add_element(element_code($urandom_range(0, 10)),
                                                     e == hit_at, -1);
         forced = -1;
         if (kind == 2) begin
            if ($urandom_range(0, 1) == 1) forced = longint'($urandom_range(0, doc_bytes.size() + 9));
            else forced = longint'($urandom);
         end
         finish_document(forced, kind == 1, (kind == 3) ? $urandom_range(1, 6) : 0);
      end
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic load_key(logic [63:0] chars, logic [3:0] len);
      write_csr(CSR_KEY_CHARS, chars);
      key_chars_cfg = chars;
      write_csr(CSR_KEY_LENGTH, {{(CSR_DATA_BITS-KEY_LENGTH_BITS){1'b0}}, len});
      key_length_cfg = len;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (request_feed.size() != 0 || req_valid || expected_verdicts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
         burst_left  = 0;
         gap_left    = 0;
         clear_scan();
      end else begin
         if (req_valid && !req_stall) scan_request(req_payload);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (request_feed.size() > 0) begin
               req_valid   <= 1'b1;
               req_payload <= request_feed.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_mode = 0;
         mode_left  = 0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ((mode_left % 5) < 2);
         endcase
      end
   end

   function automatic void report_mismatch(string what, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%s: expected %0d/%02h/%0d, got %0d/%02h/%0d (status/type/offset)",
                  what, want.status, want.element_type, want.value_offset,
                  got.status, got.element_type, got.value_offset);
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            report_mismatch("verdict with none pending", '0, rsp_payload);
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_payload.status !== want.status ||
                rsp_payload.element_type !== want.element_type ||
                rsp_payload.value_offset !== want.value_offset)
               report_mismatch("verdict mismatch", want, rsp_payload);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      int unsigned setting, directed_requests, directed_buffers;
      logic [63:0] kc;
      logic [3:0]  kl;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_key(64'h0000_0000_0079_656B, 4'd3);   // "key"
      for (int t = 0; t < 9; t++) begin
         add_element(element_code(t), 1'b0, -1);
         add_element(element_code(t), 1'b1, -1);
         finish_document(-1, 1'b0, 0);
      end
      add_element(8'h7F, 1'b0, -1);               // unknown type
      add_element(T_INT32, 1'b1, -1);
      finish_document(-1, 1'b0, 0);
      finish_document(-1, 1'b0, 0);               // empty document
      add_element(T_BOOL, 1'b1, -1);
      finish_document(32'h0001_0000, 1'b0, 0);    // one past the largest length
      add_element(T_BOOL, 1'b1, -1);
      finish_document(32'hFFFF_FFFF, 1'b0, 0);
      add_element(T_INT64, 1'b1, -1);
      finish_document(65535, 1'b0, 0);           // largest length
      add_element(T_INT32, 1'b1, -1);
      finish_document(7, 1'b0, 0);                // key runs past the document
      add_element(T_DOCUMENT, 1'b0, 2);           // sub-document length below 4
      add_element(T_INT32, 1'b1, -1);
      finish_document(-1, 1'b0, 0);
      add_element(T_ARRAY, 1'b0, 0);
      add_element(T_BOOL, 1'b1, -1);
      finish_document(-1, 1'b0, 0);
      add_element(T_STRING, 1'b0, 0);             // no room for a further element
      finish_document(-1, 1'b0, 0);
      add_element(T_STRING, 1'b0, -1);            // elements run out
      add_element(T_INT32, 1'b0, -1);
      finish_document(-1, 1'b0, 0);
      add_element(T_DOUBLE, 1'b1, -1);
      finish_document(-1, 1'b1, 0);               // cut short
      add_element(T_INT32, 1'b1, -1);
      finish_document(-1, 1'b0, 5);               // bytes after the verdict
      doc_bytes.push_back(8'h00);                 // single-byte buffer
      feed_buffer();
      wait_idle();

      directed_requests = fed_requests;
      directed_buffers  = buffers_fed;
      setting = 0;
      while (fed_requests - directed_requests < RANDOM_REQUESTS ||
             buffers_fed - directed_buffers < MIN_BUFFERS) begin
         kc = {$urandom, $urandom};
         case (setting % 6)
            0: begin
               kc = '1;
               kl = 4'd8;
            end
            1: begin
               kc = '0;
               kl = 4'd0;
            end
            2: begin
               kc = kc | 64'h0101_0101_0101_0101;
               kl = 4'd15;
            end
            3: begin
               kc[$urandom_range(0, 7)*8 +: 8] = 8'h00;
               kl = 4'd8;
            end
            4: kl = 4'($urandom_range(0, 15));
            default: kl = 4'($urandom_range(1, 8));
         endcase
         load_key(kc, kl);
         repeat (2) queue_random_buffer();
         wait_idle();
         setting++;
      end

      if (mismatches == 0 && expected_verdicts.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
